// ===== rtl/core/fpr_pkg.sv =====
// Package for the framed packet receiver: sizes, register indexes, reset
// values and the hand-off record from the frame parser to the drain unit.
// No dependencies.
`default_nettype none

package fpr_pkg;

  // Body store geometry
  localparam int BODY_DEPTH = 64;
  localparam int BODY_AW    = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
  // Lengths must fit the store and the 6-bit result fields
  localparam int LEN_LIMIT  = (BODY_DEPTH < 64) ? BODY_DEPTH : 64;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int MAXL_W = 7;
  localparam int CFG_AW = 2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MAX_LENGTH = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd2;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd3;
  localparam logic [MAXL_W-1:0] MAX_LENGTH_RST = 7'd64;

  // Parser to drain: a good frame closed, read out count words
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] flen;
  } fpr_drain_req_t;

endpackage : fpr_pkg

`default_nettype wire

// ===== rtl/core/fpr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : fpr_ram

`default_nettype wire

// ===== rtl/core/fpr_parser.sv =====
// Frame parser: configuration registers, hunt/length/body/end sequencer and
// the write side of the body store. Depends on fpr_pkg.
`default_nettype none

module fpr_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [fpr_pkg::CFG_AW-1:0]    cfg_index_i,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    cfg_data_i,
  // Accepted received word
  input  wire logic                          accept_i,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    rx_byte_i,
  // Body store write port
  output logic                               wr_en_o,
  output logic      [fpr_pkg::BODY_AW-1:0]   wr_addr_o,
  output logic      [fpr_pkg::BYTE_W-1:0]    wr_data_o,
  // Drain request
  output fpr_pkg::fpr_drain_req_t            drain_req_o
);

  import fpr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_END    = 4'b1000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    exp_q, exp_d;
  logic [IDX_W-1:0]    rlen_q, rlen_d;
  logic [BYTE_W-1:0]   start_byte_q, end_byte_q;
  logic [MAXL_W-1:0]   max_len_q;
  logic                len_ok;
  logic [CNT_W-1:0]    cnt_inc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      end_byte_q   <= END_BYTE_RST;
      max_len_q    <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_BYTE: start_byte_q <= cfg_data_i;
        CFG_END_BYTE:   end_byte_q   <= cfg_data_i;
        CFG_MAX_LENGTH: max_len_q    <= cfg_data_i[MAXL_W-1:0];
        default: ;
      endcase
    end
  end

  // Length must be below the limit register and the store size
  assign len_ok = ({1'b0, rx_byte_i} < {2'b00, max_len_q}) &&
                  (rx_byte_i < BYTE_W'(LEN_LIMIT));
  assign cnt_inc = cnt_q + CNT_W'(1);

  // Sequencer
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    exp_d       = exp_q;
    rlen_d      = rlen_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = BODY_AW'(cnt_q[IDX_W-1:0]);
    wr_data_o   = rx_byte_i;
    drain_req_o = '{start: 1'b0, count: cnt_q, flen: rlen_q};
    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == start_byte_q) begin
            phase_d = PH_LENGTH;
            cnt_d   = '0;
            exp_d   = CNT_W'(1);
          end
        end
        PH_LENGTH: begin
          if (len_ok) begin
            rlen_d  = rx_byte_i[IDX_W-1:0];
            exp_d   = (rx_byte_i == '0) ? CNT_W'(1) : rx_byte_i[CNT_W-1:0];
            cnt_d   = '0;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          wr_en_o = (cnt_q < CNT_W'(LEN_LIMIT));
          cnt_d   = cnt_inc;
          if (cnt_inc >= exp_q) begin
            phase_d = PH_END;
          end
        end
        default: begin
          // End byte position: good close starts the read-out
          drain_req_o.start = (rx_byte_i == end_byte_q) && (cnt_q != '0);
          phase_d = PH_HUNT;
          cnt_d   = '0;
          exp_d   = CNT_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      exp_q   <= CNT_W'(1);
      rlen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
      rlen_q  <= rlen_d;
    end
  end

endmodule : fpr_parser

`default_nettype wire

// ===== rtl/core/fpr_drain.sv =====
// Drain unit: walks the body store after a good frame and presents one
// result word at a time through an output register. Depends on fpr_pkg.
`default_nettype none

module fpr_drain (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  fpr_pkg::fpr_drain_req_t            req_i,
  output logic                               busy_o,
  // Body store read port
  output logic                               rd_en_o,
  output logic      [fpr_pkg::BODY_AW-1:0]   rd_addr_o,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    rd_data_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [fpr_pkg::BYTE_W-1:0]    body_byte_o,
  output logic      [fpr_pkg::IDX_W-1:0]     byte_index_o,
  output logic      [fpr_pkg::IDX_W-1:0]     frame_length_o,
  output logic                               is_last_o
);

  import fpr_pkg::*;

  logic               active_q;
  logic               pend_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   pend_idx_q;
  logic [CNT_W-1:0]   total_q;
  logic [IDX_W-1:0]   flen_q;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [IDX_W-1:0]   out_flen_q;
  logic               out_last_q;
  logic               issue;
  logic [CNT_W-1:0]   idx_next;
  logic [CNT_W-1:0]   pend_next;

  // Read only when the output register is free at the next edge
  assign issue     = active_q && !pend_q && (!out_valid_q || !out_stall_i);
  assign idx_next  = {1'b0, idx_q} + CNT_W'(1);
  assign pend_next = {1'b0, pend_idx_q} + CNT_W'(1);
  assign rd_en_o   = issue;
  assign rd_addr_o = BODY_AW'(idx_q);
  assign busy_o    = active_q || pend_q;

  // Read sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      pend_q <= issue;
      if (req_i.start) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (issue) begin
        idx_q <= idx_next[IDX_W-1:0];
        if (idx_next == total_q) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // Frame attributes and the index of the read in flight
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      total_q <= req_i.count;
      flen_q  <= req_i.flen;
    end
    if (issue) begin
      pend_idx_q <= idx_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Whole word held here, so a new frame cannot alter a stalled word
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_byte_q <= rd_data_i;
      out_idx_q  <= pend_idx_q;
      out_flen_q <= flen_q;
      out_last_q <= (pend_next == total_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign body_byte_o    = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign frame_length_o = out_flen_q;
  assign is_last_o      = out_last_q;

endmodule : fpr_drain

`default_nettype wire

// ===== rtl/core/framed_packet_receiver.sv =====
// Top level of the framed packet receiver: parser, body store and drain.
// Depends on fpr_pkg, fpr_ram, fpr_parser and fpr_drain.
//
//   Channel  Direction  Handshake                Payload
//   rx       in         rx_valid_i / rx_stall_o  rx_byte_i
//   out      out        out_valid_o / out_stall_i
//                                                body_byte_o, byte_index_o,
//                                                frame_length_o, is_last_o
//   cfg      in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// Received words are taken whenever rx is not stalled. After a good end word the
// body is read from the store, each result word passing the registered read of the
// store and then the output register, with no new read while one is in flight; rx is
// stalled from the cycle after the end word until the last read data is in the output
// register, and for longer while the result side stalls the drain.
// Reset is asynchronous; the store itself is not cleared, every entry read
// is written earlier in the same frame. A stalled result only holds the drain.
`default_nettype none

module framed_packet_receiver (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fpr_pkg::CFG_AW-1:0]    cfg_index_i,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    cfg_data_i,
  input  wire logic                          rx_valid_i,
  output logic                               rx_stall_o,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [fpr_pkg::BYTE_W-1:0]    body_byte_o,
  output logic      [fpr_pkg::IDX_W-1:0]     byte_index_o,
  output logic      [fpr_pkg::IDX_W-1:0]     frame_length_o,
  output logic                               is_last_o
);

  import fpr_pkg::*;

  logic                 busy;
  logic                 accept;
  logic                 wr_en;
  logic [BODY_AW-1:0]   wr_addr;
  logic [BYTE_W-1:0]    wr_data;
  logic                 rd_en;
  logic [BODY_AW-1:0]   rd_addr;
  logic [BYTE_W-1:0]    rd_data;
  fpr_drain_req_t       drain_req;

  assign rx_stall_o = busy;
  assign accept     = rx_valid_i && !busy;

  fpr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .drain_req_o (drain_req)
  );

  // Body store
  fpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BODY_DEPTH)
  ) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  fpr_drain u_drain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (drain_req),
    .busy_o         (busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .body_byte_o    (body_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .is_last_o      (is_last_o)
  );

endmodule : framed_packet_receiver

`default_nettype wire

// ===== tb/fpr_frame_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the framed packet receiver: watches the rx, cfg and out ports,
// predicts body words from the received bytes and compares. Depends on fpr_pkg.
module fpr_frame_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fpr_pkg::CFG_AW-1:0]    cfg_index_i,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    cfg_data_i,
  input  wire logic                          rx_valid_i,
  input  wire logic                          rx_stall_i,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [fpr_pkg::BYTE_W-1:0]    body_byte_i,
  input  wire logic [fpr_pkg::IDX_W-1:0]     byte_index_i,
  input  wire logic [fpr_pkg::IDX_W-1:0]     frame_length_i,
  input  wire logic                          is_last_i,
  output int                                 pending_o,
  output int                                 fail_count_o
);
  import fpr_pkg::*;

  typedef enum logic [1:0] {
    HUNT_START,
    TAKE_LENGTH,
    TAKE_BODY,
    TAKE_END
  } parse_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [IDX_W-1:0]  frame_length;
    logic              is_last;
  } body_word_t;

  // Shadow of the configuration registers
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;
  logic [MAXL_W-1:0] max_length;

  // Shadow of the parser
  parse_state_e      parse_state;
  int                body_count;
  int                want_count;
  logic [IDX_W-1:0]  frame_len;
  logic [BYTE_W-1:0] body_mem [BODY_DEPTH];

  body_word_t expected_words[$];
  int         errors = 0;

  assign fail_count_o = errors;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic restart_hunt();
    parse_state = HUNT_START;
    body_count  = 0;
    want_count  = 1;
  endtask

  // One received word through the parser; a good end word queues the body
  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    body_word_t w;
    case (parse_state)
      HUNT_START: begin
        if (b == start_byte) begin
          parse_state = TAKE_LENGTH;
          body_count  = 0;
          want_count  = 1;
        end
      end
      TAKE_LENGTH: begin
        // rejected lengths are skipped, still waiting for a length
        if (int'(b) < int'(max_length) && int'(b) < LEN_LIMIT) begin
          frame_len   = b[IDX_W-1:0];
          want_count  = (b == '0) ? 1 : int'(b);
          body_count  = 0;
          parse_state = TAKE_BODY;
        end
      end
      TAKE_BODY: begin
        if (body_count < BODY_DEPTH) body_mem[body_count] = b;
        body_count = (body_count + 1) & 'h7F;
        if (body_count >= want_count) parse_state = TAKE_END;
      end
      default: begin
        // a bad end word drops the frame and is not taken as a start
        if (b == end_byte) begin
          for (int i = 0; i < body_count && i < BODY_DEPTH && i < 64; i++) begin
            w.body_byte    = body_mem[i];
            w.byte_index   = IDX_W'(i);
            w.frame_length = frame_len;
            w.is_last      = (i + 1 == body_count);
            expected_words.push_back(w);
          end
        end
        restart_hunt();
      end
    endcase
  endtask

  task automatic check_body_word();
    body_word_t want;
    if (expected_words.size() == 0) begin
      report($sformatf("body word 0x%0h index %0d with nothing expected",
                       body_byte_i, byte_index_i));
    end else begin
      want = expected_words.pop_front();
      if (body_byte_i !== want.body_byte)
        report($sformatf("body_byte got 0x%0h, want 0x%0h (index %0d)",
                         body_byte_i, want.body_byte, want.byte_index));
      if (byte_index_i !== want.byte_index)
        report($sformatf("byte_index got %0d, want %0d", byte_index_i, want.byte_index));
      if (frame_length_i !== want.frame_length)
        report($sformatf("frame_length got %0d, want %0d (index %0d)",
                         frame_length_i, want.frame_length, want.byte_index));
      if (is_last_i !== want.is_last)
        report($sformatf("is_last got %0b, want %0b (index %0d)",
                         is_last_i, want.is_last, want.byte_index));
    end
  endtask

  // Sample all channels at the clock edge; register writes land first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte = START_BYTE_RST;
      end_byte   = END_BYTE_RST;
      max_length = MAX_LENGTH_RST;
      frame_len  = '0;
      restart_hunt();
      expected_words.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_BYTE: start_byte = cfg_data_i;
          CFG_END_BYTE:   end_byte   = cfg_data_i;
          CFG_MAX_LENGTH: max_length = cfg_data_i[MAXL_W-1:0];
          default: ;
        endcase
      end
      if (rx_valid_i && !rx_stall_i) parse_rx_byte(rx_byte_i);
      if (out_valid_i && !out_stall_i) check_body_word();
      pending_o <= expected_words.size();
    end
  end

endmodule

// ===== tb/framed_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the framed packet receiver: clock, reset, frame stimulus
// and verdict. Depends on fpr_pkg, framed_packet_receiver and fpr_frame_checker.
module framed_packet_receiver_tb;
  import fpr_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  localparam int TARGET_BYTES = 320;
  localparam int DRAIN_SLACK  = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 34;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_AW-1:0]   cfg_index_i = CFG_START_BYTE;
  logic [BYTE_W-1:0]   cfg_data_i  = '0;
  logic                rx_valid_i  = 1'b0;
  logic [BYTE_W-1:0]   rx_byte_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                rx_stall_o;
  logic                out_valid_o;
  logic [BYTE_W-1:0]   body_byte_o;
  logic [IDX_W-1:0]    byte_index_o;
  logic [IDX_W-1:0]    frame_length_o;
  logic                is_last_o;

  int pending_words;
  int fail_count;
  int cycle_count = 0;
  int sent_bytes  = 0;
  bit no_idle     = 1'b0;

  // Register values as last written, used to build frames
  logic [BYTE_W-1:0] cur_start = START_BYTE_RST;
  logic [BYTE_W-1:0] cur_end   = END_BYTE_RST;
  logic [MAXL_W-1:0] cur_max   = MAX_LENGTH_RST;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  framed_packet_receiver u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .body_byte_o    (body_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .is_last_o      (is_last_o)
  );

  fpr_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_i     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .body_byte_i    (body_byte_o),
    .byte_index_i   (byte_index_o),
    .frame_length_i (frame_length_o),
    .is_last_i      (is_last_o),
    .pending_o      (pending_words),
    .fail_count_o   (fail_count)
  );

  // Random back-pressure on the result side
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // One word on rx, with a random gap before it; valid stays up between words with no gap
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  // Drop valid and wait until every expected word is out and the drain is done
  task automatic settle();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                            input logic [BYTE_W-1:0] m);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_START_BYTE;
    cfg_data_i  <= s;
    @(posedge clk_i);
    cfg_index_i <= CFG_END_BYTE;
    cfg_data_i  <= e;
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_LENGTH;
    cfg_data_i  <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cur_start = s;
    cur_end   = e;
    cur_max   = m[MAXL_W-1:0];
  endtask

  function automatic int length_cap();
    return (int'(cur_max) < LEN_LIMIT) ? int'(cur_max) : LEN_LIMIT;
  endfunction

  // Mostly short bodies, now and then anything below the cap
  function automatic int pick_length();
    int cap;
    int r;
    cap = length_cap();
    r   = $urandom_range(99);
    if (r < 80) return $urandom_range((cap - 1 < 7) ? cap - 1 : 7, 0);
    if (r < 95) return $urandom_range(cap - 1, 0);
    return cap - 1;
  endfunction

  // start, rejected lengths, length, body, end (good or corrupted)
  task automatic send_frame(input int len, input bit good_end, input int rejects);
    int body_len;
    body_len = (len == 0) ? 1 : len;
    send_byte(cur_start);
    repeat (rejects) send_byte(BYTE_W'($urandom_range(255, length_cap())));
    send_byte(BYTE_W'(len));
    repeat (body_len) send_byte(BYTE_W'($urandom_range(255)));
    send_byte(good_end ? cur_end : cur_end ^ BYTE_W'($urandom_range(255, 1)));
  endtask

  initial begin
    int phase_no;
    int budget;
    int kind;
    int r;
    logic [BYTE_W-1:0] maxl;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values: zero length taken as one
    send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h03);
    // length at the limit ignored, start value inside the frame is plain data
    send_byte(8'h02); send_byte(8'h40); send_byte(8'h02);
    send_byte(8'h02); send_byte(8'h00); send_byte(8'h03);
    // bad end equal to the start value drops the frame and does not reopen one
    send_byte(8'h02); send_byte(8'h01); send_byte(8'hAA);
    send_byte(8'h02); send_byte(8'h01);
    // end value while hunting
    send_byte(8'h03);
    settle();

    // max_length 0: no length is ever taken
    write_regs(8'h00, 8'hFF, 8'h00);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
    settle();
    // max_length 1: only a zero length is taken, frame still open from above
    write_regs(8'h00, 8'hFF, 8'h01);
    send_byte(8'h00); send_byte(8'h7F); send_byte(8'hFF);
    settle();
    // max_length field at its top; the 64 limit still rejects 64
    write_regs(8'hFF, 8'h00, 8'hFF);
    send_byte(8'hFF); send_byte(8'h40); send_byte(8'h01);
    send_byte(8'h80); send_byte(8'h00);
    settle();

    // Random phases, each with its own register setting
    phase_no = 0;
    while (sent_bytes < TARGET_BYTES) begin
      r = $urandom_range(99);
      if (r < 15)      maxl = 8'd2;
      else if (r < 30) maxl = 8'd64;
      else if (r < 36) maxl = BYTE_W'($urandom_range(127, 65));
      else             maxl = BYTE_W'($urandom_range(64, 2));
      write_regs(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), maxl);
      no_idle = (phase_no == 2);
      budget  = sent_bytes + (no_idle ? 90 : $urandom_range(60, 30));
      while (sent_bytes < budget && sent_bytes < TARGET_BYTES) begin
        kind = $urandom_range(99);
        if (kind < 70)      send_frame(pick_length(), 1'b1, 0);
        else if (kind < 80) send_frame(pick_length(), 1'b0, 0);
        else if (kind < 88) send_frame(pick_length(), 1'b1, $urandom_range(3, 1));
        else repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
      end
      settle();
      no_idle = 1'b0;
      phase_no++;
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
